// File: src/hks_pkg.sv
`default_nettype none

package hks_pkg;

    localparam int unsigned BUCKETS_DEF = 256;
    localparam int unsigned WAYS_DEF    = 4;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 11;

    localparam logic [KEY_W-1:0] JH_INIT = 32'hdeadbeef;
    localparam logic [KEY_W-1:0] JH_LEN  = 32'd4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FIND  = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH_A,
        S_HASH_B,
        S_READ,
        S_CLEAR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic hash_a;
        logic hash_b;
        logic rd;
        logic sweep;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic    sweep_last;
        logic    out_busy;
    } sts_t;

    // one lookup3 mixing step: t ^= s; t -= rotl(s, r)
    function automatic logic [KEY_W-1:0] jh_mix(
        input logic [KEY_W-1:0] t,
        input logic [KEY_W-1:0] s,
        input int unsigned      r
    );
        logic [KEY_W-1:0] rot;
        rot = (s << r) | (s >> (KEY_W - r));
        return (t ^ s) - rot;
    endfunction

endpackage

`default_nettype wire

// File: src/hks_if.sv
`default_nettype none

interface hks_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_seed;

    modport source (output valid, output hash_seed, input ready);
    modport sink (input valid, input hash_seed, output ready);
endinterface

interface hks_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink (input valid, input action, input key, output ready);
endinterface

interface hks_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [1:0]  status;
    logic [10:0] item_count;

    modport source (output valid, output found, output status, output item_count, input ready);
    modport sink (input valid, input found, input status, input item_count, output ready);
endinterface

`default_nettype wire

// File: src/hks_ctrl.sv
`default_nettype none

module hks_ctrl
    import hks_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    input  wire action_t req_action,
    output logic         req_ready,
    input  wire sts_t    sts,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_action)
                        ACT_FIND, ACT_ADD: state_next = S_HASH_A;
                        ACT_CLEAR:         state_next = S_CLEAR;
                        ACT_NONE:          state_next = S_FINISH;
                    endcase
                end
            end
            S_HASH_A: state_next = S_HASH_B;
            S_HASH_B: state_next = S_READ;
            S_READ:   state_next = S_FINISH;
            S_CLEAR:
            begin
                if (sts.sweep_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the previous result has been taken
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready  = (state_reg == S_IDLE);
        cmd        = '0;
        cmd.load   = (state_reg == S_IDLE) && req_valid;
        cmd.hash_a = (state_reg == S_HASH_A);
        cmd.hash_b = (state_reg == S_HASH_B);
        cmd.rd     = (state_reg == S_READ);
        cmd.sweep  = (state_reg == S_INIT) || (state_reg == S_CLEAR);
        cmd.finish = (state_reg == S_FINISH) && !sts.out_busy;
    end

    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_INIT |=> state_reg != S_INIT)
        else $error("table sweep after reset restarted");

    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg != S_IDLE)
        else $error("accepted word did not start work");

    a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep && sts.sweep_last |=> !cmd.sweep)
        else $error("sweep ran past last bucket");

endmodule

`default_nettype wire

// File: src/hks_dp.sv
`default_nettype none

module hks_dp
    import hks_pkg::*;
#(
    parameter int unsigned BUCKETS = BUCKETS_DEF,
    parameter int unsigned WAYS    = WAYS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    input  wire logic [KEY_W-1:0]    cfg_seed,
    input  wire action_t             req_action,
    input  wire logic [KEY_W-1:0]    req_key,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic                rsp_ready,
    output logic                     rsp_valid,
    output logic                     rsp_found,
    output logic [STATUS_W-1:0]      rsp_status,
    output logic [COUNT_W-1:0]       rsp_count
);

    localparam int unsigned IDX_W  = $clog2(BUCKETS);
    localparam int unsigned FILL_W = $clog2(WAYS + 1);
    localparam int unsigned ROW_W  = WAYS * KEY_W;

    logic [KEY_W-1:0]  seed_reg;
    action_t           action_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  a_reg;
    logic [KEY_W-1:0]  b_reg;
    logic [KEY_W-1:0]  c_reg;
    logic [IDX_W-1:0]  sweep_addr_reg;
    logic [FILL_W-1:0] fill_q_reg;
    logic [ROW_W-1:0]  row_q_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;
    logic              rsp_valid_reg;
    logic              found_reg;
    status_t           status_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [FILL_W-1:0] fill_mem [BUCKETS];
    logic [ROW_W-1:0]  row_mem [BUCKETS];

    logic [KEY_W-1:0]  init_val;
    logic [KEY_W-1:0]  ha_c1, ha_a1, ha_b1, ha_c2;
    logic [KEY_W-1:0]  hb_a2, hb_b2, hb_c3;
    logic [IDX_W-1:0]  bucket;

    logic              hit;
    logic              full;
    logic              add_ok;
    logic [ROW_W-1:0]  row_new;
    logic              found_next;
    status_t           status_next;

    logic              fill_we;
    logic [IDX_W-1:0]  fill_waddr;
    logic [FILL_W-1:0] fill_wdata;
    logic              row_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_valid)
        begin
            seed_reg <= cfg_seed;
        end
    end

    // lookup3 final mix, split between the hash_a and hash_b commands
    assign init_val = seed_reg + JH_INIT + JH_LEN;
    assign ha_c1 = jh_mix(c_reg, b_reg, 14);
    assign ha_a1 = jh_mix(a_reg, ha_c1, 11);
    assign ha_b1 = jh_mix(b_reg, ha_a1, 25);
    assign ha_c2 = jh_mix(ha_c1, ha_b1, 16);
    assign hb_a2 = jh_mix(a_reg, c_reg, 4);
    assign hb_b2 = jh_mix(b_reg, hb_a2, 14);
    assign hb_c3 = jh_mix(c_reg, hb_b2, 24);
    assign bucket = c_reg[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg <= ACT_NONE;
        end
        else if (cmd.load)
        begin
            action_reg <= req_action;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= req_key;
            a_reg      <= req_key + init_val;
            b_reg      <= init_val;
            c_reg      <= init_val;
        end
        else if (cmd.hash_a)
        begin
            a_reg <= ha_a1;
            b_reg <= ha_b1;
            c_reg <= ha_c2;
        end
        else if (cmd.hash_b)
        begin
            c_reg <= hb_c3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_addr_reg <= sweep_addr_reg + 1'b1;
        end
    end

    // bucket memories
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (row_we)
        begin
            row_mem[bucket] <= row_new;
        end
        if (cmd.rd)
        begin
            fill_q_reg <= fill_mem[bucket];
            row_q_reg  <= row_mem[bucket];
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        row_new = row_q_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if ((FILL_W'(w) < fill_q_reg) && (row_q_reg[w*KEY_W +: KEY_W] == key_reg))
            begin
                hit = 1'b1;
            end
            if (FILL_W'(w) == fill_q_reg)
            begin
                row_new[w*KEY_W +: KEY_W] = key_reg;
            end
        end
    end

    assign full   = (fill_q_reg >= FILL_W'(WAYS));
    assign add_ok = (action_reg == ACT_ADD) && !hit && !full;

    always_comb
    begin
        found_next  = 1'b0;
        status_next = ST_DONE;
        total_next  = total_reg;
        unique case (action_reg)
            ACT_FIND:
            begin
                found_next = hit;
            end
            ACT_ADD:
            begin
                found_next = hit;
                if (hit)
                begin
                    status_next = ST_PRESENT;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    total_next = total_reg + 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                total_next = '0;
            end
            ACT_NONE:
            begin
                total_next = total_reg;
            end
        endcase
    end

    assign fill_we    = cmd.sweep || (cmd.finish && add_ok);
    assign fill_waddr = cmd.sweep ? sweep_addr_reg : bucket;
    assign fill_wdata = cmd.sweep ? '0 : fill_q_reg + 1'b1;
    assign row_we     = cmd.finish && add_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                total_reg     <= total_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            found_reg  <= found_next;
            status_reg <= status_next;
            count_reg  <= total_next;
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.sweep_last = (sweep_addr_reg == IDX_W'(BUCKETS - 1));
        sts.out_busy   = rsp_valid_reg && !rsp_ready;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign rsp_found  = found_reg;
    assign rsp_status = status_reg;
    assign rsp_count  = count_reg;

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we && !cmd.sweep |-> fill_q_reg < FILL_W'(WAYS))
        else $error("bucket fill pushed past its ways");

    a_total_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.finish |=> $stable(total_reg))
        else $error("key count moved outside a finish");

    a_no_duplicate_store: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> !hit && (action_reg == ACT_ADD))
        else $error("stored a key that was already present");

endmodule

`default_nettype wire

// File: src/hashed_key_set_unit.sv
// find or add: an accepted word steps through HASH_A, HASH_B, READ and FINISH; the result is registered
// on leaving FINISH, and a new word is taken only once the unit is back in IDLE (hashing, then a bucket read)
// clear sweeps the bucket fill memory, then answers
// the none action code skips hashing and goes straight to FINISH to answer
// reset: asynchronous, active low; a sweep over all BUCKETS clears the fill memory, req.ready stays low
// meanwhile; seed resets to zero, config writes are taken at any time
`default_nettype none

module hashed_key_set_unit
    import hks_pkg::*;
#(
    parameter int unsigned BUCKETS = BUCKETS_DEF,
    parameter int unsigned WAYS    = WAYS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    hks_cfg_if.sink   cfg,
    hks_req_if.sink   req,
    hks_rsp_if.source rsp
);

    cmd_t    cmd;
    sts_t    sts;
    action_t req_action;
    logic    rsp_found;
    logic [STATUS_W-1:0] rsp_status;
    logic [COUNT_W-1:0]  rsp_count;
    logic    rsp_valid;
    logic    req_ready;

    assign req_action = action_t'(req.action);
    assign cfg.ready  = 1'b1;
    assign req.ready  = req_ready;

    hks_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req_action),
        .req_ready  (req_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    hks_dp #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_seed   (cfg.hash_seed),
        .req_action (req_action),
        .req_key    (req.key),
        .cmd        (cmd),
        .sts        (sts),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp_valid),
        .rsp_found  (rsp_found),
        .rsp_status (rsp_status),
        .rsp_count  (rsp_count)
    );

    assign rsp.valid      = rsp_valid;
    assign rsp.found      = rsp_found;
    assign rsp.status     = rsp_status;
    assign rsp.item_count = rsp_count;

endmodule

`default_nettype wire
